### rtl/hrlp_pkg.sv
// Shared types and constants for the HTTP request line parser.
package hrlp_pkg;

    // One request byte with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } req_beat_t;

    // One verdict on a request line
    typedef struct packed {
        logic        status;
        logic [11:0] line_bytes;
        logic [10:0] method_offset;
        logic [3:0]  method_len;
        logic [10:0] target_offset;
        logic [5:0]  target_len;
        logic [10:0] version_offset;
        logic [3:0]  version_len;
    } res_beat_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_UNDER = 8'h5F;
    localparam logic [7:0] CHR_DASH  = 8'h2D;

    localparam int unsigned VER_PREFIX_LEN = 5;
    localparam int unsigned VER_LEN_SAT    = 15;

    // "HTTP/"
    localparam logic [7:0] VER_PREFIX [VER_PREFIX_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

endpackage

### rtl/hrlp_core.sv
// Request line state: character classes, token phases, counters and verdict.
module hrlp_core #(
    parameter int MAX_LINE   = 2048,
    parameter int METHOD_MAX = 8,
    parameter int TARGET_MAX = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hrlp_pkg::req_beat_t beat,
    output logic                fire,
    output hrlp_pkg::res_beat_t result
);
    import hrlp_pkg::*;

    localparam int TLEN_A   = (METHOD_MAX > TARGET_MAX) ? METHOD_MAX : TARGET_MAX;
    localparam int TLEN_TOP = ((TLEN_A > VER_LEN_SAT) ? TLEN_A : VER_LEN_SAT) + 1;
    localparam int TLEN_W   = ($clog2(TLEN_TOP + 1) > 6) ? $clog2(TLEN_TOP + 1) : 6;
    localparam int POS_W    = ($clog2(MAX_LINE + 1) > 12) ? $clog2(MAX_LINE + 1) : 12;

    typedef enum logic [2:0] {
        PH_PRE_METHOD,
        PH_METHOD,
        PH_PRE_TARGET,
        PH_TARGET,
        PH_PRE_VERSION,
        PH_VERSION,
        PH_TAIL
    } phase_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_target_char(input logic [7:0] b);
        return is_alpha(b) || ((b >= 8'h30) && (b <= 8'h39))
            || (b == CHR_DOT) || (b == CHR_UNDER) || (b == CHR_DASH);
    endfunction

    phase_t              phase_reg, phase_next, cur_phase;
    logic [POS_W-1:0]    pos_reg, pos_next, cur_pos, pos_inc;
    logic [TLEN_W-1:0]   tlen_reg, tlen_next, cur_tlen, tlen_inc;
    logic                cr_reg, cr_next, cur_cr;
    logic [2:0]          pfx_reg, pfx_next, cur_pfx;
    logic                given_reg;
    logic [10:0]         m_off_reg, m_off_next, cur_m_off;
    logic [3:0]          m_len_reg, m_len_next, cur_m_len;
    logic [10:0]         t_off_reg, t_off_next, cur_t_off;
    logic [5:0]          t_len_reg, t_len_next, cur_t_len;
    logic [10:0]         v_off_reg, v_off_next, cur_v_off;
    logic [3:0]          v_len_reg, v_len_next, cur_v_len;

    logic [7:0] b;
    logic       ws, live, lf_end, early_fail, char_fail, ok_path, fail, good;

    always_comb
    begin
        b     = beat.data_byte;
        ws    = is_ws(b);
        live  = step && (beat.first_byte || !given_reg);

        // A first byte starts from a cleared parse
        cur_phase = beat.first_byte ? PH_PRE_METHOD : phase_reg;
        cur_pos   = beat.first_byte ? '0 : pos_reg;
        cur_tlen  = beat.first_byte ? '0 : tlen_reg;
        cur_cr    = beat.first_byte ? 1'b0 : cr_reg;
        cur_pfx   = beat.first_byte ? '0 : pfx_reg;
        cur_m_off = beat.first_byte ? '0 : m_off_reg;
        cur_m_len = beat.first_byte ? '0 : m_len_reg;
        cur_t_off = beat.first_byte ? '0 : t_off_reg;
        cur_t_len = beat.first_byte ? '0 : t_len_reg;
        cur_v_off = beat.first_byte ? '0 : v_off_reg;
        cur_v_len = beat.first_byte ? '0 : v_len_reg;

        phase_next = cur_phase;
        pos_next   = cur_pos;
        tlen_next  = cur_tlen;
        cr_next    = cur_cr;
        pfx_next   = cur_pfx;
        m_off_next = cur_m_off;
        m_len_next = cur_m_len;
        t_off_next = cur_t_off;
        t_len_next = cur_t_len;
        v_off_next = cur_v_off;
        v_len_next = cur_v_len;

        tlen_inc  = cur_tlen + 1'b1;
        pos_inc   = cur_pos + 1'b1;
        char_fail = 1'b0;

        lf_end     = (b == CHR_LF) && cur_cr;
        early_fail = !lf_end && ((cur_pos >= POS_W'(MAX_LINE)) || (b == CHR_NUL));

        if (!lf_end && !early_fail)
        begin
            unique case (cur_phase)
                PH_PRE_METHOD:
                begin
                    if (!ws)
                    begin
                        if (!is_alpha(b))
                            char_fail = 1'b1;
                        else
                        begin
                            m_off_next = cur_pos[10:0];
                            tlen_next  = TLEN_W'(1);
                            phase_next = PH_METHOD;
                        end
                    end
                end
                PH_METHOD:
                begin
                    if (ws)
                    begin
                        m_len_next = cur_tlen[3:0];
                        phase_next = PH_PRE_TARGET;
                    end
                    else if (!is_alpha(b))
                        char_fail = 1'b1;
                    else
                    begin
                        tlen_next = tlen_inc;
                        char_fail = tlen_inc > TLEN_W'(METHOD_MAX);
                    end
                end
                PH_PRE_TARGET:
                begin
                    if (!ws)
                    begin
                        if (b != CHR_SLASH)
                            char_fail = 1'b1;
                        else
                        begin
                            t_off_next = cur_pos[10:0];
                            tlen_next  = '0;
                            phase_next = PH_TARGET;
                        end
                    end
                end
                PH_TARGET:
                begin
                    if (ws)
                    begin
                        if (cur_tlen == '0)
                            char_fail = 1'b1;
                        else
                        begin
                            t_len_next = cur_tlen[5:0];
                            phase_next = PH_PRE_VERSION;
                        end
                    end
                    else if (!is_target_char(b))
                        char_fail = 1'b1;
                    else
                    begin
                        tlen_next = tlen_inc;
                        char_fail = tlen_inc > TLEN_W'(TARGET_MAX);
                    end
                end
                PH_PRE_VERSION:
                begin
                    if (!ws)
                    begin
                        if (b != VER_PREFIX[0])
                            char_fail = 1'b1;
                        else
                        begin
                            v_off_next = cur_pos[10:0];
                            tlen_next  = TLEN_W'(1);
                            pfx_next   = 3'd1;
                            phase_next = PH_VERSION;
                        end
                    end
                end
                PH_VERSION:
                begin
                    if (ws)
                    begin
                        if (cur_pfx < 3'(VER_PREFIX_LEN))
                            char_fail = 1'b1;
                        else
                        begin
                            v_len_next = cur_tlen[3:0];
                            phase_next = PH_TAIL;
                        end
                    end
                    else
                    begin
                        if (cur_tlen < TLEN_W'(VER_LEN_SAT))
                            tlen_next = tlen_inc;
                        if (cur_pfx < 3'(VER_PREFIX_LEN))
                        begin
                            if (b != VER_PREFIX[cur_pfx])
                                char_fail = 1'b1;
                            else
                                pfx_next = cur_pfx + 3'd1;
                        end
                    end
                end
                PH_TAIL:
                begin
                    // Further tokens are ignored
                end
                default:
                begin
                end
            endcase
        end

        ok_path = !lf_end && !early_fail && !char_fail;
        if (ok_path)
        begin
            cr_next = (b == CHR_CR);
            if (cur_pos < POS_W'(MAX_LINE))
                pos_next = pos_inc;
        end

        fail = early_fail || char_fail || (ok_path && beat.last_byte);
        fire = live && (lf_end || fail);
        good = lf_end && (cur_phase == PH_TAIL);

        result = '0;
        if (good)
        begin
            result.status         = STATUS_OK;
            result.line_bytes     = pos_inc[11:0];
            result.method_offset  = cur_m_off;
            result.method_len     = cur_m_len;
            result.target_offset  = cur_t_off;
            result.target_len     = cur_t_len;
            result.version_offset = cur_v_off;
            result.version_len    = cur_v_len;
        end
        else
            result.status = STATUS_BAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE_METHOD;
            pos_reg   <= '0;
            tlen_reg  <= '0;
            cr_reg    <= 1'b0;
            pfx_reg   <= '0;
            given_reg <= 1'b1;
            m_off_reg <= '0;
            m_len_reg <= '0;
            t_off_reg <= '0;
            t_len_reg <= '0;
            v_off_reg <= '0;
            v_len_reg <= '0;
        end
        else if (live)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tlen_reg  <= tlen_next;
            cr_reg    <= cr_next;
            pfx_reg   <= pfx_next;
            given_reg <= lf_end || fail;
            m_off_reg <= m_off_next;
            m_len_reg <= m_len_next;
            t_off_reg <= t_off_next;
            t_len_reg <= t_len_next;
            v_off_reg <= v_off_next;
            v_len_reg <= v_len_next;
        end
    end

endmodule

### rtl/http_request_line_parser.sv
// Top level of the HTTP request line parser: beat registers and handshakes.
//
// Usage
//   req channel: one request byte per beat (req_valid, req_stall, req_beat).
//   first_byte opens a request and clears any unfinished parse; last_byte
//   marks the end of the buffer. Bytes that follow a verdict without a new
//   first_byte are swallowed.
//   res channel: at most one verdict beat per request (res_valid, res_stall,
//   res_beat), at the LF closing CR LF or at the first byte that dooms the
//   line. A bad request carries zeros in every field but status.
// Timing
//   Path: a byte taken into the input register passes through the core and its
//   verdict is loaded into the result register, from which it is offered.
//   Throughput: one byte per cycle while req_stall is low; the byte step is a
//   single pass of character compares and counter updates.
// Reset and stall
//   Reset empties both beat registers and leaves the parser waiting for a
//   first_byte. While res_stall holds a waiting verdict, one more byte is
//   taken into the input register and req_stall then rises until the
//   verdict drains.
module http_request_line_parser #(
    parameter int MAX_LINE   = 2048,
    parameter int METHOD_MAX = 8,
    parameter int TARGET_MAX = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  hrlp_pkg::req_beat_t req_beat,
    output logic                res_valid,
    input  logic                res_stall,
    output hrlp_pkg::res_beat_t res_beat
);
    import hrlp_pkg::*;

    logic      in_vld_reg;
    req_beat_t in_beat_reg;
    logic      out_vld_reg;
    res_beat_t out_beat_reg;

    logic      advance;
    logic      core_fire;
    res_beat_t core_res;

    // The held byte moves on whenever the result slot is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || !res_stall);
    assign req_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!req_stall)
            in_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
            in_beat_reg <= req_beat;
    end

    hrlp_core #(
        .MAX_LINE   (MAX_LINE),
        .METHOD_MAX (METHOD_MAX),
        .TARGET_MAX (TARGET_MAX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (in_beat_reg),
        .fire   (core_fire),
        .result (core_res)
    );

    // Result register: loads a fresh verdict, else empties once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && core_fire)
            out_vld_reg <= 1'b1;
        else if (!res_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_fire)
            out_beat_reg <= core_res;
    end

    assign res_valid = out_vld_reg;
    assign res_beat  = out_beat_reg;

    // Input side only ever stalls behind a held verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("req_stall without a stalled verdict");

    // Bad verdicts carry nothing but status
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_beat.status == STATUS_BAD)) |->
        ((res_beat.line_bytes == '0) && (res_beat.method_len == '0)
         && (res_beat.target_len == '0) && (res_beat.version_len == '0)))
        else $error("bad request verdict with non-zero fields");

    // An accepted line has at least the full version prefix
    a_ok_version: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_beat.status == STATUS_OK)) |->
        (res_beat.version_len >= 4'(VER_PREFIX_LEN)))
        else $error("accepted line with short version token");

endmodule
